### src/efmt_pkg.sv
// Shared types and constants of the multiturn encoder tracker.
`default_nettype none
package efmt_pkg;

   // Field widths fixed by the frame format.
   localparam int POS_FIELD_W    = 13;
   localparam int SPEED_W        = 16;
   localparam int CURRENT_W      = 16;
   localparam int TEMP_W         = 8;
   localparam int COEF_W         = 16;
   localparam int SINGLE_W       = 25;
   localparam int TURNS_W        = 16;
   localparam int TOTAL_W        = 40;
   localparam int SPEED_AVG_W    = 27;
   localparam int CURRENT_AVG_W  = 24;
   localparam int SPEED_SAMPLE_W = 33;
   localparam int CURRENT_SAMPLE_W = 24;

   // 360 degrees in Q16.
   localparam logic [SINGLE_W-1:0] FULL_CIRCLE_Q16 = 25'd23592960;

   localparam logic signed [TURNS_W-1:0] TURNS_MAX = 16'sh7FFF;
   localparam logic signed [TURNS_W-1:0] TURNS_MIN = 16'sh8000;

   // Register reset values.
   localparam logic [COEF_W-1:0] SPEED_COEF_RESET      = 16'd32768;
   localparam logic [COEF_W-1:0] CURRENT_COEF_RESET    = 16'd32768;
   localparam logic [COEF_W-1:0] ANGLE_PER_COUNT_RESET = 16'd2880;
   localparam logic [COEF_W-1:0] DPS_PER_RPM_RESET     = 16'd1536;

   typedef enum logic [1:0] {
      CSR_SPEED_COEF      = 2'd0,
      CSR_CURRENT_COEF    = 2'd1,
      CSR_ANGLE_PER_COUNT = 2'd2,
      CSR_DPS_PER_RPM     = 2'd3
   } csr_index_type;

endpackage
`default_nettype wire

### src/encoder_feedback_multiturn_tracker.sv
// Top level of the multiturn encoder tracker with speed and current smoothing.
//
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  position_raw, speed_rpm, current_raw, temperature
//  rsp       out        rsp_valid / rsp_stall  position, angles, turn count, filtered values
//  csr       in         csr_write              csr_index, csr_wdata
//
// One beat is accepted every clock cycle while the result side keeps up. A beat passes an
// input register, a product register that holds the two scaling multiplications, and the
// result register, from which its result is offered on the rsp channel.
// Reset is synchronous and active high; it empties the pipeline, clears the tracking state
// and loads the register defaults. A stall on the result side first fills the empty stages,
// and only when all three hold a beat is req_stall raised.
`default_nettype none
module encoder_feedback_multiturn_tracker #(
   parameter int ENCODER_BITS = 13
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,

   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [efmt_pkg::POS_FIELD_W-1:0]       req_position_raw,
   input  wire logic signed [efmt_pkg::SPEED_W-1:0]    req_speed_rpm,
   input  wire logic signed [efmt_pkg::CURRENT_W-1:0]  req_current_raw,
   input  wire logic [efmt_pkg::TEMP_W-1:0]            req_temperature,

   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [efmt_pkg::POS_FIELD_W-1:0]            rsp_position_out,
   output logic [efmt_pkg::SINGLE_W-1:0]               rsp_single_turn_angle,
   output logic signed [efmt_pkg::TURNS_W-1:0]         rsp_turn_count,
   output logic signed [efmt_pkg::TOTAL_W-1:0]         rsp_multiturn_angle,
   output logic signed [efmt_pkg::SPEED_AVG_W-1:0]     rsp_speed_filtered,
   output logic signed [efmt_pkg::CURRENT_AVG_W-1:0]   rsp_current_filtered,
   output logic [efmt_pkg::TEMP_W-1:0]                 rsp_temperature_out,

   input  wire logic                                   csr_write,
   input  wire efmt_pkg::csr_index_type                csr_index,
   input  wire logic [efmt_pkg::COEF_W-1:0]            csr_wdata
);
   import efmt_pkg::*;

   // Only the low ENCODER_BITS bits of the position field count.
   localparam int POS_W = (ENCODER_BITS < POS_FIELD_W) ? ENCODER_BITS : POS_FIELD_W;
   localparam logic [POS_FIELD_W-1:0] POS_MASK = POS_FIELD_W'((64'd1 << POS_W) - 64'd1);

   // Configuration registers.
   logic [COEF_W-1:0] speed_coef_ff;
   logic [COEF_W-1:0] current_coef_ff;
   logic [COEF_W-1:0] angle_per_count_ff;
   logic [COEF_W-1:0] dps_per_rpm_ff;

   // Input stage.
   logic                          s1_valid_ff;
   logic [POS_FIELD_W-1:0]        s1_pos_ff;
   logic signed [SPEED_W-1:0]     s1_rpm_ff;
   logic signed [CURRENT_W-1:0]   s1_cur_ff;
   logic [TEMP_W-1:0]             s1_temp_ff;

   // Product stage.
   logic                              s2_valid_ff;
   logic [POS_FIELD_W-1:0]            s2_pos_ff;
   logic [SINGLE_W-1:0]               s2_single_ff;
   logic signed [SPEED_SAMPLE_W-1:0]  s2_speed_sample_ff;
   logic signed [CURRENT_W-1:0]       s2_cur_ff;
   logic [TEMP_W-1:0]                 s2_temp_ff;

   // Tracking state.
   logic [POS_FIELD_W-1:0]              last_pos_ff;
   logic signed [TURNS_W-1:0]           turns_ff;
   logic signed [SPEED_AVG_W-1:0]       speed_avg_ff;
   logic signed [CURRENT_AVG_W-1:0]     cur_avg_ff;

   // Result register.
   logic                                rsp_valid_ff;
   logic [POS_FIELD_W-1:0]              rsp_pos_ff;
   logic [SINGLE_W-1:0]                 rsp_single_ff;
   logic signed [TOTAL_W-1:0]           rsp_total_ff;
   logic [TEMP_W-1:0]                   rsp_temp_ff;

   logic [SINGLE_W-1:0]                 single_in;
   logic signed [SPEED_SAMPLE_W-1:0]    speed_sample_in;
   logic signed [TURNS_W-1:0]           turns_in;
   logic signed [TOTAL_W-1:0]           total_in;
   logic signed [SPEED_AVG_W-1:0]       speed_avg_in;
   logic signed [CURRENT_AVG_W-1:0]     cur_avg_in;
   logic signed [CURRENT_SAMPLE_W-1:0]  cur_sample;

   logic out_ready;
   logic s2_ready;
   logic s1_ready;
   logic req_accept;
   logic s1_move;
   logic s2_move;

   // Each stage takes a new beat when it is empty or its own beat moves on.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign s2_move    = s2_valid_ff && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_coef_ff      <= SPEED_COEF_RESET;
         current_coef_ff    <= CURRENT_COEF_RESET;
         angle_per_count_ff <= ANGLE_PER_COUNT_RESET;
         dps_per_rpm_ff     <= DPS_PER_RPM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SPEED_COEF:      speed_coef_ff      <= csr_wdata;
            CSR_CURRENT_COEF:    current_coef_ff    <= csr_wdata;
            CSR_ANGLE_PER_COUNT: angle_per_count_ff <= csr_wdata;
            CSR_DPS_PER_RPM:     dps_per_rpm_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pos_ff  <= req_position_raw & POS_MASK;
         s1_rpm_ff  <= req_speed_rpm;
         s1_cur_ff  <= req_current_raw;
         s1_temp_ff <= req_temperature;
      end
   end

   efmt_scale u_scale (
      .position        (s1_pos_ff),
      .speed_rpm       (s1_rpm_ff),
      .angle_per_count (angle_per_count_ff),
      .dps_per_rpm     (dps_per_rpm_ff),
      .single_angle    (single_in),
      .speed_sample    (speed_sample_in)
   );

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_pos_ff          <= s1_pos_ff;
         s2_single_ff       <= single_in;
         s2_speed_sample_ff <= speed_sample_in;
         s2_cur_ff          <= s1_cur_ff;
         s2_temp_ff         <= s1_temp_ff;
      end
   end

   // The current sample is the raw reading taken to Q8.
   assign cur_sample = {s2_cur_ff, 8'h00};

   efmt_ema #(
      .AVG_W    (SPEED_AVG_W),
      .SAMPLE_W (SPEED_SAMPLE_W)
   ) u_speed_ema (
      .average      (speed_avg_ff),
      .sample       (s2_speed_sample_ff),
      .coef         (speed_coef_ff),
      .average_next (speed_avg_in)
   );

   efmt_ema #(
      .AVG_W    (CURRENT_AVG_W),
      .SAMPLE_W (CURRENT_SAMPLE_W)
   ) u_current_ema (
      .average      (cur_avg_ff),
      .sample       (cur_sample),
      .coef         (current_coef_ff),
      .average_next (cur_avg_in)
   );

   efmt_unwrap #(
      .ENCODER_BITS (ENCODER_BITS)
   ) u_unwrap (
      .position        (s2_pos_ff),
      .last_position   (last_pos_ff),
      .turns           (turns_ff),
      .single_angle    (s2_single_ff),
      .turns_next      (turns_in),
      .multiturn_angle (total_in)
   );

   // The tracking state moves only with the beat that enters the result register, so a
   // stalled beat is never counted twice. Before the first frame the last position is zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff  <= '0;
         turns_ff     <= '0;
         speed_avg_ff <= '0;
         cur_avg_ff   <= '0;
      end else if (s2_move) begin
         last_pos_ff  <= s2_pos_ff;
         turns_ff     <= turns_in;
         speed_avg_ff <= speed_avg_in;
         cur_avg_ff   <= cur_avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_pos_ff    <= s2_pos_ff;
         rsp_single_ff <= s2_single_ff;
         rsp_total_ff  <= total_in;
         rsp_temp_ff   <= s2_temp_ff;
      end
   end

   // The state registers double as the turn count and filter outputs of the last beat.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_position_out      = rsp_pos_ff;
   assign rsp_single_turn_angle = rsp_single_ff;
   assign rsp_turn_count        = turns_ff;
   assign rsp_multiturn_angle   = rsp_total_ff;
   assign rsp_speed_filtered    = speed_avg_ff;
   assign rsp_current_filtered  = cur_avg_ff;
   assign rsp_temperature_out   = rsp_temp_ff;

   // An empty result register never holds back the input side.
   a_no_stall_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("req_stall raised with an empty result register");

   // The turn count steps by at most one turn per beat.
   a_turn_step : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (turns_ff == $past(turns_ff) ||
                         turns_ff == $past(turns_ff) + 16'sd1 ||
                         turns_ff == $past(turns_ff) - 16'sd1))
      else $error("turn count jumped by more than one turn");

   // Tracking state holds unless a beat moves into the result register.
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !s2_move |=> ($stable(turns_ff) && $stable(last_pos_ff) &&
                    $stable(speed_avg_ff) && $stable(cur_avg_ff)))
      else $error("tracking state changed without a beat");

   // The single-turn angle offered never exceeds a full circle.
   a_single_clamped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_single_ff <= FULL_CIRCLE_Q16))
      else $error("single-turn angle beyond 360 degrees");

endmodule
`default_nettype wire

### src/efmt_scale.sv
// Scaling of position to a clamped single-turn angle and of speed to degrees per second.
`default_nettype none
module efmt_scale (
   input  wire logic [efmt_pkg::POS_FIELD_W-1:0]           position,
   input  wire logic signed [efmt_pkg::SPEED_W-1:0]        speed_rpm,
   input  wire logic [efmt_pkg::COEF_W-1:0]                angle_per_count,
   input  wire logic [efmt_pkg::COEF_W-1:0]                dps_per_rpm,
   output logic [efmt_pkg::SINGLE_W-1:0]                   single_angle,
   output logic signed [efmt_pkg::SPEED_SAMPLE_W-1:0]      speed_sample
);
   import efmt_pkg::*;

   localparam int PROD_W = POS_FIELD_W + COEF_W;

   logic [PROD_W-1:0]                 angle_prod;
   logic signed [SPEED_SAMPLE_W-1:0]  rpm_ext;
   logic signed [SPEED_SAMPLE_W-1:0]  dps_ext;

   assign angle_prod = PROD_W'(position) * PROD_W'(angle_per_count);

   // Anything past a full circle is held at 360 degrees.
   assign single_angle = (angle_prod > PROD_W'(FULL_CIRCLE_Q16)) ? FULL_CIRCLE_Q16
                                                                  : angle_prod[SINGLE_W-1:0];

   assign rpm_ext      = SPEED_SAMPLE_W'(speed_rpm);
   assign dps_ext      = $signed({{(SPEED_SAMPLE_W-COEF_W){1'b0}}, dps_per_rpm});
   assign speed_sample = rpm_ext * dps_ext;

endmodule
`default_nettype wire

### src/efmt_ema.sv
// Exponential average update with round to nearest and saturation to the state width.
`default_nettype none
module efmt_ema #(
   parameter int AVG_W    = 27,
   parameter int SAMPLE_W = 33
) (
   input  wire logic signed [AVG_W-1:0]     average,
   input  wire logic signed [SAMPLE_W-1:0]  sample,
   input  wire logic [efmt_pkg::COEF_W-1:0] coef,
   output logic signed [AVG_W-1:0]          average_next
);
   import efmt_pkg::*;

   localparam int OLD_W = AVG_W + COEF_W + 2;
   localparam int NEW_W = SAMPLE_W + COEF_W + 1;
   localparam int ACC_W = ((OLD_W > NEW_W) ? OLD_W : NEW_W) + 1;
   localparam int RND_W = ACC_W - COEF_W;
   localparam logic signed [RND_W-1:0] AVG_MAX =
      RND_W'((64'sd1 <<< (AVG_W - 1)) - 64'sd1);
   localparam logic signed [RND_W-1:0] AVG_MIN = ~AVG_MAX;
   localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(64'sd1 <<< (COEF_W - 1));

   logic [COEF_W:0]             keep;
   logic signed [OLD_W-1:0]     old_part;
   logic signed [NEW_W-1:0]     new_part;
   logic signed [ACC_W-1:0]     acc;
   logic signed [RND_W-1:0]     rounded;

   assign keep     = (COEF_W+1)'(1 << COEF_W) - (COEF_W+1)'(coef);
   assign old_part = OLD_W'(average) * $signed({1'b0, keep});
   assign new_part = NEW_W'(sample) * $signed({1'b0, coef});
   assign acc      = ACC_W'(old_part) + ACC_W'(new_part) + HALF_LSB;

   // Dropping the low bits of a two's complement value floors it, so ties go upwards.
   assign rounded  = $signed(acc[ACC_W-1:COEF_W]);

   always_comb begin
      if (rounded > AVG_MAX) begin
         average_next = AVG_W'(AVG_MAX);
      end else if (rounded < AVG_MIN) begin
         average_next = AVG_W'(AVG_MIN);
      end else begin
         average_next = AVG_W'(rounded);
      end
   end

endmodule
`default_nettype wire

### src/efmt_unwrap.sv
// Turn counting from position jumps and saturated total angle.
`default_nettype none
module efmt_unwrap #(
   parameter int ENCODER_BITS = 13
) (
   input  wire logic [efmt_pkg::POS_FIELD_W-1:0]    position,
   input  wire logic [efmt_pkg::POS_FIELD_W-1:0]    last_position,
   input  wire logic signed [efmt_pkg::TURNS_W-1:0] turns,
   input  wire logic [efmt_pkg::SINGLE_W-1:0]       single_angle,
   output logic signed [efmt_pkg::TURNS_W-1:0]      turns_next,
   output logic signed [efmt_pkg::TOTAL_W-1:0]      multiturn_angle
);
   import efmt_pkg::*;

   localparam int DIFF_W = 18;
   localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(1 << (ENCODER_BITS - 1));
   localparam int WIDE_W = TOTAL_W + 2;
   localparam logic signed [WIDE_W-1:0] TOTAL_MAX =
      WIDE_W'((64'sd1 <<< (TOTAL_W - 1)) - 64'sd1);
   localparam logic signed [WIDE_W-1:0] TOTAL_MIN = ~TOTAL_MAX;

   logic signed [DIFF_W-1:0] diff;
   logic signed [WIDE_W-1:0] total_wide;

   assign diff = $signed({{(DIFF_W-POS_FIELD_W){1'b0}}, position})
               - $signed({{(DIFF_W-POS_FIELD_W){1'b0}}, last_position});

   // A jump up by more than half a turn is a backward wrap, a jump down a forward one.
   always_comb begin
      turns_next = turns;
      if (diff > HALF_TURN) begin
         if (turns != TURNS_MIN) begin
            turns_next = turns - 16'sd1;
         end
      end else if (diff < -HALF_TURN) begin
         if (turns != TURNS_MAX) begin
            turns_next = turns + 16'sd1;
         end
      end
   end

   assign total_wide = WIDE_W'(turns_next)
                     * $signed({{(WIDE_W-SINGLE_W){1'b0}}, FULL_CIRCLE_Q16})
                     + $signed({{(WIDE_W-SINGLE_W){1'b0}}, single_angle});

   always_comb begin
      if (total_wide > TOTAL_MAX) begin
         multiturn_angle = TOTAL_W'(TOTAL_MAX);
      end else if (total_wide < TOTAL_MIN) begin
         multiturn_angle = TOTAL_W'(TOTAL_MIN);
      end else begin
         multiturn_angle = TOTAL_W'(total_wide);
      end
   end

endmodule
`default_nettype wire
